/* rtl/nsd_pkg.sv */
// ----------------------------------------------------------------------------
// nsd_pkg: shared types and constants of the sentence deframer
// Character codes, line modes, status codes, result and queue push types.
// ----------------------------------------------------------------------------
package nsd_pkg;

	// characters of the line format
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;

	// line modes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_TRACK = 2'd1;
	localparam logic [1:0] MODE_SKIP  = 2'd2;
	localparam logic [1:0] MODE_OVER  = 2'd3;

	// closing status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SUM_BAD = 2'd1;
	localparam logic [1:0] ST_FORMAT  = 2'd2;
	localparam logic [1:0] ST_LONG    = 2'd3;

	// result queue geometry
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	// one result item
	typedef struct packed {
		logic [7:0] line_length;
		logic [7:0] computed_sum;
		logic [1:0] status;
		logic       sentence_end;
		logic       payload_valid;
		logic [7:0] payload_char;
	} res_t;

	// up to two results pushed per accepted character, v1 implies v0
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

endpackage

/* rtl/nmea_sentence_deframer.sv */
// ----------------------------------------------------------------------------
// nmea_sentence_deframer: sentence deframer with checksum check
// Path: a result passes through the result queue and the output register to the master side.
// Throughput: one character per cycle; s_tready drops while the result
// queue holds more than two entries (a held return can yield two results).
// Reset: arst_n clears line state, queue pointers and output valid.
// ----------------------------------------------------------------------------
module nmea_sentence_deframer #(
	parameter int unsigned MAX_LINE = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] payload_char, [9:8] status,
	                               // [17:10] computed_sum, [25:18] line_length
	output logic        m_tuser,   // [0] payload_valid
	output logic        m_tlast    // sentence_end
);

	nsd_pkg::push_t push;
	nsd_pkg::res_t  rd_data;
	nsd_pkg::res_t  out_data;
	logic           room;
	logic           rd_valid;
	logic           pop;

	// front: classify characters
	nsd_front #(
		.MAX_LINE (MAX_LINE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.room     (room),
		.push     (push)
	);

	// queue between front and back
	nsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.rd_valid (rd_valid),
		.rd_data  (rd_data),
		.pop      (pop)
	);

	// back: output register
	nsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (rd_valid),
		.rd_data   (rd_data),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	// output beat packing
	assign m_tdata = {6'd0, out_data.line_length, out_data.computed_sum,
	                  out_data.status, out_data.payload_char};
	assign m_tuser = out_data.payload_valid;
	assign m_tlast = out_data.sentence_end;

endmodule

/* rtl/nsd_front.sv */
// ----------------------------------------------------------------------------
// nsd_front: character classifier and line tracker
// Accepts one character per beat, keeps the line state and emits up to two
// results per character into the result queue.
// ----------------------------------------------------------------------------
module nsd_front #(
	parameter int unsigned MAX_LINE = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_char,
	input  logic              room,
	output nsd_pkg::push_t    push
);

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] pos;
		logic [7:0] sum;
		logic [7:0] w0;
		logic [7:0] w1;
		logic [7:0] w2;
		logic [1:0] fill;
		logic       pend;
	} lst_t;

	typedef struct packed {
		lst_t          st;
		logic          has;
		nsd_pkg::res_t res;
	} step_t;

	localparam logic [7:0] MAX_POS = 8'(MAX_LINE);

	lst_t  st_q;
	lst_t  st_n;
	lst_t  t;
	step_t oa;
	step_t ob;
	logic  ha;
	logic  hb;
	logic  run_b;
	logic  acc;

	// hex digit value, bit 4 set when not a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= nsd_pkg::CH_ZERO && c <= nsd_pkg::CH_NINE)
			v = {1'b0, 4'(c - nsd_pkg::CH_ZERO)};
		else if (c >= nsd_pkg::CH_LA && c <= nsd_pkg::CH_LF_HEX)
			v = {1'b0, 4'(c - nsd_pkg::CH_LA + 8'd10)};
		else if (c >= nsd_pkg::CH_UA && c <= nsd_pkg::CH_UF)
			v = {1'b0, 4'(c - nsd_pkg::CH_UA + 8'd10)};
		return v;
	endfunction

	// one ordinary character
	function automatic step_t do_char(input lst_t s, input logic [7:0] c);
		step_t o;
		logic [7:0] ev;
		o = '0;
		o.st = s;
		ev = s.w0;
		case (s.mode)
			nsd_pkg::MODE_IDLE: begin
				if (c == nsd_pkg::CH_DOLLAR || c == nsd_pkg::CH_BANG) begin
					o.st.mode = nsd_pkg::MODE_TRACK;
					o.st.pos  = 8'd1;
					o.st.sum  = 8'd0;
					o.st.fill = 2'd0;
					o.st.w0   = 8'd0;
					o.st.w1   = 8'd0;
					o.st.w2   = 8'd0;
				end else begin
					o.st.mode = nsd_pkg::MODE_SKIP;
				end
			end
			nsd_pkg::MODE_TRACK: begin
				if (s.pos >= MAX_POS) begin
					o.st.mode = nsd_pkg::MODE_OVER;
				end else begin
					o.st.pos = s.pos + 8'd1;
					if (s.fill != 2'd3) begin
						case (s.fill)
							2'd0:    o.st.w0 = c;
							2'd1:    o.st.w1 = c;
							default: o.st.w2 = c;
						endcase
						o.st.fill = s.fill + 2'd1;
					end else begin
						o.st.w0  = s.w1;
						o.st.w1  = s.w2;
						o.st.w2  = c;
						o.st.sum = s.sum ^ ev;
						if (s.pos >= 8'd6) begin
							o.has               = 1'b1;
							o.res.payload_char  = ev;
							o.res.payload_valid = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// line feed closes the line
	function automatic step_t do_lf(input lst_t s);
		step_t o;
		logic [4:0] hi;
		logic [4:0] lo;
		logic [1:0] stat;
		o = '0;
		o.st = s;
		o.st.mode = nsd_pkg::MODE_IDLE;
		hi = hex_val(s.w1);
		lo = hex_val(s.w2);
		if (s.fill != 2'd3 || s.w0 != nsd_pkg::CH_STAR || hi[4] || lo[4])
			stat = nsd_pkg::ST_FORMAT;
		else if ({hi[3:0], lo[3:0]} != s.sum)
			stat = nsd_pkg::ST_SUM_BAD;
		else
			stat = nsd_pkg::ST_OK;
		if (s.mode == nsd_pkg::MODE_OVER) begin
			o.has        = 1'b1;
			o.res.status = nsd_pkg::ST_LONG;
		end else if (s.mode == nsd_pkg::MODE_TRACK) begin
			o.has        = 1'b1;
			o.res.status = stat;
		end
		o.res.sentence_end = 1'b1;
		o.res.computed_sum = s.sum;
		o.res.line_length  = s.pos;
		return o;
	endfunction

	assign in_ready = room;
	assign acc      = in_valid & room;

	// held carriage return first, then the new character
	always_comb begin
		t      = st_q;
		t.pend = 1'b0;
		st_n   = t;
		oa     = '0;
		ob     = '0;
		run_b  = 1'b1;
		if (st_q.pend) begin
			if (in_char == nsd_pkg::CH_LF) begin
				oa    = do_lf(t);
				st_n  = oa.st;
				run_b = 1'b0;
			end else begin
				oa = do_char(t, nsd_pkg::CH_CR);
				t  = oa.st;
			end
		end
		if (run_b) begin
			if (in_char == nsd_pkg::CH_CR) begin
				st_n      = t;
				st_n.pend = 1'b1;
			end else if (in_char == nsd_pkg::CH_LF) begin
				ob   = do_lf(t);
				st_n = ob.st;
			end else begin
				ob   = do_char(t, in_char);
				st_n = ob.st;
			end
		end
		ha = oa.has;
		hb = ob.has;
	end

	// pack results to the low push slot first
	always_comb begin
		push.v0 = acc & (ha | hb);
		push.v1 = acc & ha & hb;
		push.r0 = ha ? oa.res : ob.res;
		push.r1 = ob.res;
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (acc) begin
			st_q <= st_n;
		end
	end

endmodule

/* rtl/nsd_queue.sv */
// ----------------------------------------------------------------------------
// nsd_queue: short result queue
// Takes up to two results per cycle and gives out one per cycle when the output stage pops.
// ----------------------------------------------------------------------------
module nsd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  nsd_pkg::push_t    push,
	output logic              room,
	output logic              rd_valid,
	output nsd_pkg::res_t     rd_data,
	input  logic              pop
);

	localparam int unsigned CW = nsd_pkg::QAW + 1;

	nsd_pkg::res_t             mem_q [nsd_pkg::QDEPTH];
	logic [nsd_pkg::QAW-1:0]   wp_q;
	logic [nsd_pkg::QAW-1:0]   rp_q;
	logic [CW-1:0]             cnt_q;
	logic                      do_pop;
	logic [CW-1:0]             n_push;

	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign do_pop   = pop & rd_valid;
	assign room     = (cnt_q <= CW'(nsd_pkg::QDEPTH - 2));
	assign n_push   = CW'(push.v0) + CW'(push.v1);

	// storage
	always_ff @(posedge clk) begin
		if (push.v0)
			mem_q[wp_q] <= push.r0;
		if (push.v1)
			mem_q[wp_q + nsd_pkg::QAW'(1)] <= push.r1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_push[nsd_pkg::QAW-1:0];
			rp_q  <= rp_q + nsd_pkg::QAW'(do_pop);
			cnt_q <= cnt_q + n_push - CW'(do_pop);
		end
	end

endmodule

/* rtl/nsd_back.sv */
// ----------------------------------------------------------------------------
// nsd_back: output stage
// Moves results from the queue into the output register toward the sink.
// ----------------------------------------------------------------------------
module nsd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_valid,
	input  nsd_pkg::res_t     rd_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output nsd_pkg::res_t     out_data
);

	logic          valid_q;
	nsd_pkg::res_t data_q;

	assign pop       = rd_valid & (~valid_q | out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (~valid_q | out_ready) begin
			valid_q <= rd_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop)
			data_q <= rd_data;
	end

endmodule
